[rtl/tgr_pkg.sv]
// shared types, codes and helpers for the touch gesture recognizer
package tgr_pkg;

	localparam int unsigned CoordW   = 16;
	localparam int unsigned TimeW    = 64;
	localparam int unsigned MsW      = 32;
	localparam int unsigned UsThrW   = 42;  // ms threshold scaled to microseconds
	localparam int unsigned DistW    = 15;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned CfgIdxW  = 2;

	localparam logic [CoordW-1:0] TapSlopReset   = 16'd10;
	localparam logic [CoordW-1:0] SwipeMinReset  = 16'd40;
	localparam logic [MsW-1:0]    TapMaxMsReset  = 32'd250;
	localparam logic [MsW-1:0]    LongPressReset = 32'd600;
	localparam logic [DistW-1:0]  SwipeSat       = 15'd32767;

	typedef enum logic [1:0] {
		MODE_DOWN = 2'd0,
		MODE_MOVE = 2'd1,
		MODE_UP   = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_TAP   = 3'd0,
		KIND_LONG  = 3'd1,
		KIND_LEFT  = 3'd2,
		KIND_RIGHT = 3'd3,
		KIND_UP    = 3'd4,
		KIND_DOWN  = 3'd5
	} kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TAP_SLOP   = 2'd0,
		REG_SWIPE_MIN  = 2'd1,
		REG_TAP_MAX    = 2'd2,
		REG_LONG_PRESS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic [TimeW-1:0]        time_us;
	} sample_t;

	typedef struct packed {
		logic                    active;
		logic                    moved;
		logic                    long_done;
		logic signed [CoordW-1:0] origin_x;
		logic signed [CoordW-1:0] origin_y;
		logic [TimeW-1:0]        origin_time;
	} track_t;

	typedef struct packed {
		logic [CoordW-1:0] tap_slop;
		logic [CoordW-1:0] swipe_min;
		logic [UsThrW-1:0] tap_max_us;
		logic [UsThrW-1:0] long_press_us;
	} cfg_t;

	typedef struct packed {
		logic                    valid;
		kind_t                   kind;
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic [TimeW-1:0]        time_us;
		logic [DistW-1:0]        swipe_dist;
	} result_t;

	// v * 1000 as (v << 10) - (v << 4) - (v << 3)
	function automatic logic [UsThrW-1:0] ms_to_us(input logic [MsW-1:0] v);
		logic [UsThrW-1:0] w;
		w = {v, 10'b0};
		return w - {6'b0, v, 4'b0} - {7'b0, v, 3'b0};
	endfunction

endpackage

[rtl/tgr_if.sv]
// channel interfaces: touch samples, gesture results, register writes
interface tgr_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             mode;
	logic signed [tgr_pkg::CoordW-1:0]      pos_x;
	logic signed [tgr_pkg::CoordW-1:0]      pos_y;
	logic [tgr_pkg::TimeW-1:0]              time_us;

	modport source (output valid, mode, pos_x, pos_y, time_us, input ready);
	modport sink (input valid, mode, pos_x, pos_y, time_us, output ready);
endinterface

interface tgr_gesture_if;
	logic                                   valid;
	logic                                   ready;
	logic [2:0]                             event_kind;
	logic signed [tgr_pkg::CoordW-1:0]      event_x;
	logic signed [tgr_pkg::CoordW-1:0]      event_y;
	logic [tgr_pkg::TimeW-1:0]              event_time_us;
	logic [tgr_pkg::DistW-1:0]              swipe_distance;

	modport source (output valid, event_kind, event_x, event_y, event_time_us,
		swipe_distance, input ready);
	modport sink (input valid, event_kind, event_x, event_y, event_time_us,
		swipe_distance, output ready);
endinterface

interface tgr_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [tgr_pkg::CfgIdxW-1:0]            index;
	logic [tgr_pkg::CfgDataW-1:0]           data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/tgr_classify.sv]
// classifies one touch sample against the tracked touch and gives the next track state
module tgr_classify (
	input  tgr_pkg::sample_t item,
	input  tgr_pkg::track_t  track,
	input  tgr_pkg::cfg_t    cfg,
	output tgr_pkg::track_t  track_next,
	output tgr_pkg::result_t result
);

	logic signed [tgr_pkg::CoordW:0] dx, dy;
	logic [tgr_pkg::CoordW:0]        dx_neg, dy_neg;
	logic [tgr_pkg::CoordW-1:0]      adx, ady;
	logic                            beyond_slop;
	logic                            moved_n;
	logic [tgr_pkg::TimeW:0]         diff_full;
	logic                            time_fwd;
	logic                            held_ge_tap, held_ge_long;
	logic                            is_swipe;
	logic [tgr_pkg::DistW-1:0]       sat_x, sat_y;

	always_comb begin
		dx = {item.pos_x[tgr_pkg::CoordW-1], item.pos_x}
			- {track.origin_x[tgr_pkg::CoordW-1], track.origin_x};
		dy = {item.pos_y[tgr_pkg::CoordW-1], item.pos_y}
			- {track.origin_y[tgr_pkg::CoordW-1], track.origin_y};
		dx_neg = -dx;
		dy_neg = -dy;
		adx = dx[tgr_pkg::CoordW] ? dx_neg[tgr_pkg::CoordW-1:0] : dx[tgr_pkg::CoordW-1:0];
		ady = dy[tgr_pkg::CoordW] ? dy_neg[tgr_pkg::CoordW-1:0] : dy[tgr_pkg::CoordW-1:0];
		beyond_slop = (adx > cfg.tap_slop) || (ady > cfg.tap_slop);
		moved_n = track.moved || beyond_slop;

		// held time compared in microseconds: floor(d/1000) >= t iff d >= 1000*t
		diff_full = {1'b0, item.time_us} - {1'b0, track.origin_time};
		time_fwd = !diff_full[tgr_pkg::TimeW] && (diff_full[tgr_pkg::TimeW-1:0] != '0);
		held_ge_tap = (cfg.tap_max_us == '0) || (time_fwd &&
			(diff_full[tgr_pkg::TimeW-1:0] >= {{(tgr_pkg::TimeW-tgr_pkg::UsThrW){1'b0}},
			cfg.tap_max_us}));
		held_ge_long = (cfg.long_press_us == '0) || (time_fwd &&
			(diff_full[tgr_pkg::TimeW-1:0] >= {{(tgr_pkg::TimeW-tgr_pkg::UsThrW){1'b0}},
			cfg.long_press_us}));

		is_swipe = (adx >= cfg.swipe_min) || (ady >= cfg.swipe_min);
		sat_x = adx[tgr_pkg::CoordW-1] ? tgr_pkg::SwipeSat : adx[tgr_pkg::DistW-1:0];
		sat_y = ady[tgr_pkg::CoordW-1] ? tgr_pkg::SwipeSat : ady[tgr_pkg::DistW-1:0];

		track_next        = track;
		result.valid      = 1'b0;
		result.kind       = tgr_pkg::KIND_TAP;
		result.pos_x      = item.pos_x;
		result.pos_y      = item.pos_y;
		result.time_us    = item.time_us;
		result.swipe_dist = '0;

		case (tgr_pkg::mode_t'(item.mode))
			tgr_pkg::MODE_DOWN: begin
				track_next.active      = 1'b1;
				track_next.moved       = 1'b0;
				track_next.long_done   = 1'b0;
				track_next.origin_x    = item.pos_x;
				track_next.origin_y    = item.pos_y;
				track_next.origin_time = item.time_us;
			end
			tgr_pkg::MODE_MOVE: begin
				if (track.active) begin
					track_next.moved = moved_n;
					if (!moved_n && !track.long_done && held_ge_long) begin
						track_next.long_done = 1'b1;
						result.valid = 1'b1;
						result.kind  = tgr_pkg::KIND_LONG;
					end
				end
			end
			tgr_pkg::MODE_UP: begin
				if (track.active) begin
					track_next.active = 1'b0;
					track_next.moved  = moved_n;
					if (is_swipe) begin
						result.valid = 1'b1;
						if (adx >= ady) begin
							// zero displacement falls to left
							result.kind = (!dx[tgr_pkg::CoordW] && dx != '0) ?
								tgr_pkg::KIND_RIGHT : tgr_pkg::KIND_LEFT;
							result.swipe_dist = sat_x;
						end else begin
							result.kind = (!dy[tgr_pkg::CoordW] && dy != '0) ?
								tgr_pkg::KIND_DOWN : tgr_pkg::KIND_UP;
							result.swipe_dist = sat_y;
						end
					end else if (!moved_n) begin
						if (!held_ge_tap) begin
							result.valid = 1'b1;
							result.kind  = tgr_pkg::KIND_TAP;
						end else if (held_ge_long && !track.long_done) begin
							track_next.long_done = 1'b1;
							result.valid = 1'b1;
							result.kind  = tgr_pkg::KIND_LONG;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/touch_gesture_recognizer.sv]
// touch gesture recognizer top level: sample register, classifier, result register
//
//   channel   dir   role     payload
//   sample    in    sink     mode, pos_x, pos_y, time_us
//   gesture   out   source   event_kind, event_x, event_y, event_time_us, swipe_distance
//   cfg       in    sink     index, data (always ready)
//
// one sample per cycle while the result is not stalled; an accepted request goes from the
// sample register through the combinational classifier into the result register
// arst_n clears the track flags and origin, the valid flags and the thresholds to reset values
// a stalled result holds a full sample register, which then takes no new request
module touch_gesture_recognizer (
	input logic        clk,
	input logic        arst_n,
	tgr_sample_if.sink   sample,
	tgr_gesture_if.source gesture,
	tgr_cfg_if.sink      cfg
);

	logic              valid_s1;
	tgr_pkg::sample_t  item_s1;
	tgr_pkg::track_t   track_q;
	tgr_pkg::track_t   track_next;
	tgr_pkg::cfg_t     cfg_q;
	tgr_pkg::result_t  result;
	logic              out_valid_q;
	tgr_pkg::result_t  out_q;
	logic              advance;

	assign advance      = !out_valid_q || gesture.ready;
	assign sample.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			item_s1.mode    <= sample.mode;
			item_s1.pos_x   <= sample.pos_x;
			item_s1.pos_y   <= sample.pos_y;
			item_s1.time_us <= sample.time_us;
		end
	end

	// thresholds kept in microseconds so the held-time checks need no divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_slop      <= tgr_pkg::TapSlopReset;
			cfg_q.swipe_min     <= tgr_pkg::SwipeMinReset;
			cfg_q.tap_max_us    <= tgr_pkg::ms_to_us(tgr_pkg::TapMaxMsReset);
			cfg_q.long_press_us <= tgr_pkg::ms_to_us(tgr_pkg::LongPressReset);
		end else if (cfg.valid && cfg.ready) begin
			case (tgr_pkg::reg_idx_t'(cfg.index))
				tgr_pkg::REG_TAP_SLOP:   cfg_q.tap_slop      <= cfg.data[tgr_pkg::CoordW-1:0];
				tgr_pkg::REG_SWIPE_MIN:  cfg_q.swipe_min     <= cfg.data[tgr_pkg::CoordW-1:0];
				tgr_pkg::REG_TAP_MAX:    cfg_q.tap_max_us    <= tgr_pkg::ms_to_us(cfg.data);
				tgr_pkg::REG_LONG_PRESS: cfg_q.long_press_us <= tgr_pkg::ms_to_us(cfg.data);
				default: begin
				end
			endcase
		end
	end

	tgr_classify u_classify (
		.item       (item_s1),
		.track      (track_q),
		.cfg        (cfg_q),
		.track_next (track_next),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && result.valid;
			if (valid_s1) begin
				track_q <= track_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && result.valid) begin
			out_q <= result;
		end
	end

	assign gesture.valid          = out_valid_q;
	assign gesture.event_kind     = out_q.kind;
	assign gesture.event_x        = out_q.pos_x;
	assign gesture.event_y        = out_q.pos_y;
	assign gesture.event_time_us  = out_q.time_us;
	assign gesture.swipe_distance = out_q.swipe_dist;

endmodule
